/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the serial adapter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property at every clock edge outside reset.
`define AKL_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// When cond holds, expect holds in the next cycle.
`define AKL_ASSERT_NEXT(lbl, clk, rst_n, cond, expect_) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expect_)) \
		else $error("assertion failed");

`else

`define AKL_ASSERT(lbl, clk, rst_n, prop)
`define AKL_ASSERT_NEXT(lbl, clk, rst_n, cond, expect_)

`endif

`endif

/* rtl/akl_pkg.sv */
// ----------------------------------------------------------------------------
// akl_pkg
// Types and constants of the serial adapter with loopback and frame source.
// ----------------------------------------------------------------------------
`default_nettype none

package akl_pkg;

	// Receive ring: interleaved over four banks so that a tick can push a
	// looped byte and a whole frame at once. Depth is a power of two.
	localparam int RX_DEPTH = 64;
	localparam int RX_AW    = $clog2(RX_DEPTH);
	localparam int RX_BANKS = 4;
	localparam int RX_BW    = $clog2(RX_BANKS);
	localparam int RX_ROWS  = RX_DEPTH / RX_BANKS;
	localparam int RX_RW    = RX_AW - RX_BW;

	// Transmit ring, power-of-two depth
	localparam int TX_DEPTH = 32;
	localparam int TX_AW    = $clog2(TX_DEPTH);

	localparam int FRAME_PERIOD = 1024;
	localparam int FRAME_W      = $clog2(FRAME_PERIOD);
	localparam int FRAME_LEN    = 3;
	localparam int TICK_W       = 12;

	localparam int BAUD_W = 9;
	localparam logic [BAUD_W-1:0] BAUD_BASE  = 9'd32;
	localparam logic [BAUD_W-1:0] BAUD_RESET = 9'd256;

	localparam logic [7:0] FRAME_MARK    = 8'hF8;
	localparam logic [7:0] STATUS_RESET  = 8'h02;
	localparam logic [7:0] CONTROL_RESET = 8'h15;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_TICK  = 2'd2,
		OP_ACK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_STATUS  = 2'd0,
		REG_CONTROL = 2'd1,
		REG_TXDATA  = 2'd2,
		REG_RXDATA  = 2'd3
	} reg_t;

	typedef struct packed {
		op_t        op;
		reg_t       addr;
		logic [7:0] wdata;
	} item_t;

	typedef struct packed {
		logic [7:0] rdata;
		logic       irq_now;
		logic [7:0] status_now;
	} result_t;

	// Receive ring write side: one port per bank
	typedef struct packed {
		logic [RX_BANKS-1:0]            we;
		logic [RX_BANKS-1:0][RX_RW-1:0] row;
		logic [RX_BANKS-1:0][7:0]       data;
	} rx_wr_t;

	typedef struct packed {
		logic             en;
		logic [RX_AW-1:0] addr;
	} rx_rd_t;

endpackage

`default_nettype wire

/* rtl/akl_in_if.sv */
// ----------------------------------------------------------------------------
// akl_in_if
// Request channel: bus access, timer tick or interrupt acknowledge.
// ----------------------------------------------------------------------------
`default_nettype none

interface akl_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [1:0] addr;
	logic [7:0] wdata;

	modport source (output valid, output op, output addr, output wdata, input ready);
	modport sink (input valid, input op, input addr, input wdata, output ready);
endinterface

`default_nettype wire

/* rtl/akl_out_if.sv */
// ----------------------------------------------------------------------------
// akl_out_if
// Response channel: read data, interrupt flag and live status.
// ----------------------------------------------------------------------------
`default_nettype none

interface akl_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] rdata;
	logic       irq_now;
	logic [7:0] status_now;

	modport source (output valid, output rdata, output irq_now, output status_now,
		input ready);
	modport sink (input valid, input rdata, input irq_now, input status_now,
		output ready);
endinterface

`default_nettype wire

/* rtl/akl_rx_ring.sv */
// ----------------------------------------------------------------------------
// akl_rx_ring
// Receive ring storage: four interleaved banks, one write port each and a
// registered read of the entry at the pop address.
// ----------------------------------------------------------------------------
`default_nettype none

module akl_rx_ring (
	input  wire logic            clk,
	input  wire akl_pkg::rx_wr_t wr,
	input  wire akl_pkg::rx_rd_t rd,
	output logic [7:0]           rd_data
);
	import akl_pkg::*;

	logic [7:0]       bank_dout [RX_BANKS];
	logic [RX_BW-1:0] sel_q;

	for (genvar b = 0; b < RX_BANKS; b++) begin : g_bank
		logic [7:0] mem [RX_ROWS];
		logic [7:0] dout_q;

		always_ff @(posedge clk) begin
			if (wr.we[b]) begin
				mem[wr.row[b]] <= wr.data[b];
			end
			if (rd.en) begin
				dout_q <= mem[rd.addr[RX_AW-1:RX_BW]];
			end
		end

		assign bank_dout[b] = dout_q;
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			sel_q <= rd.addr[RX_BW-1:0];
		end
	end

	assign rd_data = bank_dout[sel_q];

endmodule

`default_nettype wire

/* rtl/akl_outbuf.sv */
// ----------------------------------------------------------------------------
// akl_outbuf
// Result register with a skid entry, so a new result is taken while the
// previous one still waits on the response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module akl_outbuf (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire akl_pkg::result_t in_res,
	akl_out_if.source             res
);
	import akl_pkg::*;

	logic    main_v_q;
	logic    skid_v_q;
	result_t main_q;
	result_t skid_q;
	logic    take;
	logic    drain;

	assign in_ready = !skid_v_q;
	assign take     = in_valid && in_ready;
	assign drain    = !main_v_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (drain) begin
			if (skid_v_q) begin
				main_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= take;
			end
		end else if (take) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			main_q <= skid_v_q ? skid_q : in_res;
		end else if (take) begin
			skid_q <= in_res;
		end
	end

	assign res.valid      = main_v_q;
	assign res.rdata      = main_q.rdata;
	assign res.irq_now    = main_q.irq_now;
	assign res.status_now = main_q.status_now;

endmodule

`default_nettype wire

/* rtl/akl_core.sv */
// ----------------------------------------------------------------------------
// akl_core
// Request register and the single-pass update of registers, rings, baud
// counter, tick counter and interrupt flag.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module akl_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	akl_in_if.sink                cmd,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output akl_pkg::result_t      res_item,
	output akl_pkg::rx_wr_t       wr,
	output akl_pkg::rx_rd_t       rd,
	input  wire logic [7:0]       ring_rd
);
	import akl_pkg::*;

	// request stage
	logic  s1_v_q;
	item_t s1_q;
	logic  act;

	// state
	logic [4:0]        status_mid_q, status_mid_n;
	logic [7:0]        control_q, control_n;
	logic [7:0]        last_tx_q, last_tx_n;
	logic [7:0]        held_q, held_n;
	logic              from_mem_q, from_mem_n;
	logic [RX_AW-1:0]  rx_head_q, rx_head_n;
	logic [RX_AW-1:0]  rx_tail_q, rx_tail_n;
	logic [TX_AW-1:0]  tx_head_q, tx_head_n;
	logic [TX_AW-1:0]  tx_tail_q, tx_tail_n;
	logic [BAUD_W-1:0] baud_period_q, baud_period_n;
	logic [BAUD_W-1:0] baud_count_q, baud_count_n;
	logic [TICK_W-1:0] tick_q, tick_n;
	logic              irq_q, irq_n;
	logic [7:0]        tx_mem [TX_DEPTH];

	// datapath terms
	logic [RX_AW-1:0]  rx_count;
	logic [TX_AW-1:0]  tx_count;
	logic              rx_nonempty;
	logic              tx_empty;
	logic              tx_push;
	logic              is_tick;
	logic [7:0]        held_cur;
	logic [7:0]        rdata;
	logic [TICK_W-1:0] tick_inc;
	logic [BAUD_W-1:0] baud_dec;
	logic              baud_expire;
	logic              lb_take;
	logic              lb_push;
	logic [7:0]        lb_byte;
	logic              frame_hit;
	logic [RX_AW-1:0]  free0;
	logic [RX_AW-1:0]  free1;
	logic              frame_fit;
	logic [1:0]        frame_cnt;
	logic [2:0]        push_n;
	logic [7:0]        t_lo;
	logic [7:0]        t_hi;
	logic [7:0]        push_byte [RX_BANKS];

	assign act        = s1_v_q && res_ready;
	assign cmd.ready  = !s1_v_q || res_ready;
	assign res_valid  = s1_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (cmd.ready) begin
			s1_v_q <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			s1_q <= '{op: op_t'(cmd.op), addr: reg_t'(cmd.addr), wdata: cmd.wdata};
		end
	end

	assign rx_count    = rx_tail_q - rx_head_q;
	assign tx_count    = tx_tail_q - tx_head_q;
	assign rx_nonempty = rx_head_q != rx_tail_q;
	assign tx_empty    = tx_head_q == tx_tail_q;
	assign held_cur    = from_mem_q ? ring_rd : held_q;
	assign is_tick     = s1_q.op == OP_TICK;

	assign tx_push = act && s1_q.op == OP_WRITE && s1_q.addr == REG_TXDATA
		&& tx_count != TX_AW'(TX_DEPTH - 1);

	// timer tick: baud expiry moves one transmit byte, frame every period
	assign tick_inc    = tick_q + TICK_W'(1);
	assign baud_dec    = (baud_count_q != '0) ? baud_count_q - BAUD_W'(1) : baud_count_q;
	assign baud_expire = baud_dec == '0;
	assign lb_take     = baud_expire && !tx_empty;
	assign lb_byte     = tx_mem[tx_head_q];
	assign frame_hit   = tick_inc[FRAME_W-1:0] == '0;

	assign free0     = RX_AW'(RX_DEPTH - 1) - rx_count;
	assign lb_push   = lb_take && free0 != '0;
	assign free1     = free0 - RX_AW'(lb_push);
	assign frame_fit = free1 >= RX_AW'(FRAME_LEN);
	assign frame_cnt = !frame_hit ? 2'd0 : (frame_fit ? 2'(FRAME_LEN) : free1[1:0]);
	assign push_n    = {2'b00, lb_push} + {1'b0, frame_cnt};

	assign t_lo = {2'b00, tick_inc[5:0]};
	assign t_hi = {2'b00, tick_inc[11:6]};

	assign push_byte[0] = lb_push ? lb_byte : FRAME_MARK;
	assign push_byte[1] = lb_push ? FRAME_MARK : t_lo;
	assign push_byte[2] = lb_push ? t_lo : t_hi;
	assign push_byte[3] = t_hi;

	// byte j of the push lands in bank (tail + j) mod RX_BANKS
	for (genvar k = 0; k < RX_BANKS; k++) begin : g_wr
		logic [RX_BW-1:0] slot;
		logic [RX_AW-1:0] pos;

		assign slot       = RX_BW'(k) - rx_tail_q[RX_BW-1:0];
		assign pos        = rx_tail_q + RX_AW'(slot);
		assign wr.we[k]   = act && is_tick && ({1'b0, slot} < push_n);
		assign wr.row[k]  = pos[RX_AW-1:RX_BW];
		assign wr.data[k] = push_byte[slot];
	end

	always_comb begin
		status_mid_n  = status_mid_q;
		control_n     = control_q;
		last_tx_n     = last_tx_q;
		held_n        = held_q;
		from_mem_n    = from_mem_q;
		rx_head_n     = rx_head_q;
		rx_tail_n     = rx_tail_q;
		tx_head_n     = tx_head_q;
		tx_tail_n     = tx_tail_q;
		baud_period_n = baud_period_q;
		baud_count_n  = baud_count_q;
		tick_n        = tick_q;
		irq_n         = irq_q;
		rdata         = 8'h00;
		rd.en         = 1'b0;
		rd.addr       = rx_head_q;

		unique case (s1_q.op)
			OP_READ: begin
				unique case (s1_q.addr)
					REG_STATUS:  rdata = {irq_q, status_mid_q, tx_empty, rx_nonempty};
					REG_CONTROL: rdata = control_q;
					REG_TXDATA:  rdata = last_tx_q;
					REG_RXDATA: begin
						rdata = held_cur;
						// pop: holder follows the ring entry read out this cycle
						if (rx_nonempty) begin
							rd.en      = act;
							rx_head_n  = rx_head_q + RX_AW'(1);
							from_mem_n = 1'b1;
						end
					end
					default: rdata = 8'h00;
				endcase
			end
			OP_WRITE: begin
				unique case (s1_q.addr)
					REG_STATUS:  status_mid_n = s1_q.wdata[6:2];
					REG_CONTROL: begin
						control_n     = s1_q.wdata;
						baud_period_n = BAUD_BASE << s1_q.wdata[1:0];
						baud_count_n  = BAUD_BASE << s1_q.wdata[1:0];
					end
					REG_TXDATA: begin
						last_tx_n = s1_q.wdata;
						if (tx_push) begin
							tx_tail_n = tx_tail_q + TX_AW'(1);
						end
					end
					REG_RXDATA: begin
						held_n     = s1_q.wdata;
						from_mem_n = 1'b0;
					end
					default: ;
				endcase
				if (s1_q.wdata[7]) begin
					irq_n = 1'b1;
				end
			end
			OP_TICK: begin
				tick_n       = tick_inc;
				baud_count_n = baud_expire ? baud_period_q : baud_dec;
				if (lb_take) begin
					tx_head_n  = tx_head_q + TX_AW'(1);
					held_n     = lb_byte;
					from_mem_n = 1'b0;
					irq_n      = 1'b1;
				end
				if (frame_hit && frame_fit) begin
					irq_n = 1'b1;
				end
				rx_tail_n = rx_tail_q + RX_AW'(push_n);
			end
			OP_ACK: irq_n = 1'b0;
			default: ;
		endcase
	end

	assign res_item.rdata      = rdata;
	assign res_item.irq_now    = irq_n;
	assign res_item.status_now = {irq_n, status_mid_n, tx_head_n == tx_tail_n,
		rx_head_n != rx_tail_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_mid_q  <= STATUS_RESET[6:2];
			control_q     <= CONTROL_RESET;
			last_tx_q     <= 8'h00;
			held_q        <= 8'h00;
			from_mem_q    <= 1'b0;
			rx_head_q     <= '0;
			rx_tail_q     <= '0;
			tx_head_q     <= '0;
			tx_tail_q     <= '0;
			baud_period_q <= BAUD_RESET;
			baud_count_q  <= BAUD_RESET;
			tick_q        <= '0;
			irq_q         <= 1'b0;
		end else if (act) begin
			status_mid_q  <= status_mid_n;
			control_q     <= control_n;
			last_tx_q     <= last_tx_n;
			held_q        <= held_n;
			from_mem_q    <= from_mem_n;
			rx_head_q     <= rx_head_n;
			rx_tail_q     <= rx_tail_n;
			tx_head_q     <= tx_head_n;
			tx_tail_q     <= tx_tail_n;
			baud_period_q <= baud_period_n;
			baud_count_q  <= baud_count_n;
			tick_q        <= tick_n;
			irq_q         <= irq_n;
		end
	end

	always_ff @(posedge clk) begin
		if (tx_push) begin
			tx_mem[tx_tail_q] <= s1_q.wdata;
		end
	end

	`AKL_ASSERT(a_baud_nonzero, clk, arst_n, baud_count_q != '0)
	`AKL_ASSERT(a_tx_no_overrun, clk, arst_n, !tx_push || tx_count != TX_AW'(TX_DEPTH - 1))
	`AKL_ASSERT_NEXT(a_ack_clears_irq, clk, arst_n, act && s1_q.op == OP_ACK, !irq_q)
	`AKL_ASSERT_NEXT(a_pop_sets_holder_src, clk, arst_n, rd.en, from_mem_q)

endmodule

`default_nettype wire

/* rtl/acia_keyboard_link_model.sv */
// ----------------------------------------------------------------------------
// acia_keyboard_link_model
// Serial adapter with four byte registers, transmit-to-receive loopback and
// a periodic three-byte keyboard frame source.
// ----------------------------------------------------------------------------
//  channel | dir | payload                          | transfer
//  cmd     | in  | op, addr, wdata                  | valid & ready
//  res     | out | rdata, irq_now, status_now       | valid & ready
//
// One request per clock unless the response side stalls; a response passes
// through the request register, then the result register, and is offered
// on the response channel from the result register.
// The core does a single-pass update: every register and ring pointer
// moves at most once per request, and the receive ring takes up to four
// writes per tick across its four banks.
// Reset is immediate; the rings need no clearing pass.
// A stalled response is held in the result register plus one skid entry;
// with the request register that is three requests in flight before the
// request channel drops ready.
// ----------------------------------------------------------------------------
`default_nettype none

module acia_keyboard_link_model (
	input  wire logic clk,
	input  wire logic arst_n,
	akl_in_if.sink    cmd,
	akl_out_if.source res
);
	import akl_pkg::*;

	logic       core_valid;
	logic       buf_ready;
	result_t    core_res;
	rx_wr_t     ring_wr;
	rx_rd_t     ring_rd_req;
	logic [7:0] ring_rd_data;

	akl_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.res_valid (core_valid),
		.res_ready (buf_ready),
		.res_item  (core_res),
		.wr        (ring_wr),
		.rd        (ring_rd_req),
		.ring_rd   (ring_rd_data)
	);

	akl_rx_ring u_rx_ring (
		.clk     (clk),
		.wr      (ring_wr),
		.rd      (ring_rd_req),
		.rd_data (ring_rd_data)
	);

	akl_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (core_valid),
		.in_ready (buf_ready),
		.in_res   (core_res),
		.res      (res)
	);

endmodule

`default_nettype wire

/* bench/akl_checker.sv */
// ----------------------------------------------------------------------------
// akl_checker
// Watches the request and response channels of the serial adapter, keeps its
// own copy of the registers, rings, baud and frame counters, works out the
// response of every accepted request and compares the responses in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module akl_checker
	import akl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	akl_in_if    cmd,
	akl_out_if   res,
	output int   mismatches,
	output int   outstanding,
	output int   compared
);

	localparam int STAT_RX_AVAIL = 0;
	localparam int STAT_TX_EMPTY = 1;
	localparam int STAT_IRQ      = 7;

	logic [7:0]        status_q;
	logic [7:0]        control_q;
	logic [7:0]        tx_last;
	logic [7:0]        rx_held;
	logic [7:0]        rx_mem [RX_DEPTH];
	logic [7:0]        tx_mem [TX_DEPTH];
	logic [RX_AW-1:0]  rx_rd, rx_wr;
	logic [TX_AW-1:0]  tx_rd, tx_wr;
	logic [BAUD_W-1:0] baud_len, baud_cnt;
	logic [TICK_W-1:0] tick_cnt;
	logic              irq;

	result_t resp_due[$];

	task automatic flag_error(string msg);
		$display("[%0t] ERROR %s", $time, msg);
		mismatches++;
	endtask

	// A ring keeps one slot free; drop the byte when full.
	function automatic bit rx_push(logic [7:0] b);
		logic [RX_AW-1:0] nxt;
		nxt = rx_wr + 1'b1;
		if (nxt == rx_rd)
			return 1'b0;
		rx_mem[rx_wr] = b;
		rx_wr = nxt;
		return 1'b1;
	endfunction

	function automatic void refresh_status();
		status_q[STAT_RX_AVAIL] = (rx_rd != rx_wr);
		status_q[STAT_TX_EMPTY] = (tx_rd == tx_wr);
		status_q[STAT_IRQ]      = irq;
	endfunction

	function automatic void reset_model();
		status_q  = STATUS_RESET;
		control_q = CONTROL_RESET;
		tx_last   = '0;
		rx_held   = '0;
		rx_rd     = '0;
		rx_wr     = '0;
		tx_rd     = '0;
		tx_wr     = '0;
		baud_len  = BAUD_RESET;
		baud_cnt  = BAUD_RESET;
		tick_cnt  = '0;
		irq       = 1'b0;
		refresh_status();
	endfunction

	function automatic result_t adapter_step(item_t it);
		result_t          r;
		logic [7:0]       b;
		logic [TX_AW-1:0] tx_nxt;
		bit               ok;
		r.rdata = '0;
		case (it.op)
		OP_READ: begin
			case (it.addr)
			REG_STATUS:  r.rdata = status_q;
			REG_CONTROL: r.rdata = control_q;
			REG_TXDATA:  r.rdata = tx_last;
			default: begin
				// return the held byte, then pop the next one into the holder
				r.rdata = rx_held;
				if (rx_rd != rx_wr) begin
					rx_held = rx_mem[rx_rd];
					rx_rd = rx_rd + 1'b1;
				end
			end
			endcase
		end
		OP_WRITE: begin
			case (it.addr)
			REG_STATUS:  status_q = it.wdata;
			REG_CONTROL: begin
				control_q = it.wdata;
				baud_len  = BAUD_BASE << it.wdata[1:0];
				baud_cnt  = baud_len;
			end
			REG_TXDATA: begin
				tx_last = it.wdata;
				tx_nxt  = tx_wr + 1'b1;
				if (tx_nxt != tx_rd) begin
					tx_mem[tx_wr] = it.wdata;
					tx_wr = tx_nxt;
				end
			end
			default: rx_held = it.wdata;
			endcase
			if (it.wdata[7])
				irq = 1'b1;
		end
		OP_TICK: begin
			tick_cnt = tick_cnt + 1'b1;
			if (baud_cnt != 0)
				baud_cnt = baud_cnt - 1'b1;
			if (baud_cnt == 0) begin
				// loop back one byte; it lands in the holder even if the ring is full
				if (tx_rd != tx_wr) begin
					b = tx_mem[tx_rd];
					tx_rd = tx_rd + 1'b1;
					ok = rx_push(b);
					rx_held = b;
					irq = 1'b1;
				end
				baud_cnt = baud_len;
			end
			if (tick_cnt[FRAME_W-1:0] == '0) begin
				// stop the frame at the first byte that does not fit
				ok = rx_push(FRAME_MARK);
				if (ok)
					ok = rx_push({2'b00, tick_cnt[5:0]});
				if (ok)
					ok = rx_push({2'b00, tick_cnt[11:6]});
				if (ok)
					irq = 1'b1;
			end
		end
		default: irq = 1'b0;
		endcase
		refresh_status();
		r.irq_now    = irq;
		r.status_now = status_q;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		item_t   req;
		result_t want;
		if (!arst_n) begin
			reset_model();
			resp_due.delete();
			outstanding <= 0;
		end else begin
			if (cmd.valid && cmd.ready) begin
				req.op    = op_t'(cmd.op);
				req.addr  = reg_t'(cmd.addr);
				req.wdata = cmd.wdata;
				resp_due.push_back(adapter_step(req));
			end
			if (res.valid && res.ready) begin
				if (resp_due.size() == 0) begin
					flag_error("response transfer with no request waiting");
				end else begin
					want = resp_due.pop_front();
					compared++;
					if (res.rdata !== want.rdata)
						flag_error($sformatf("rdata: got %02h, expected %02h (response %0d)",
							res.rdata, want.rdata, compared));
					if (res.irq_now !== want.irq_now)
						flag_error($sformatf("irq_now: got %b, expected %b (response %0d)",
							res.irq_now, want.irq_now, compared));
					if (res.status_now !== want.status_now)
						flag_error($sformatf("status_now: got %02h, expected %02h (response %0d)",
							res.status_now, want.status_now, compared));
				end
			end
			outstanding <= resp_due.size();
		end
	end

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives register reads and writes, timer ticks and interrupt acknowledges
// into the serial adapter: a short directed pass over the registers, then
// random sequences that loop bytes back, fill and drain the rings and run
// through keyboard frames, with random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import akl_pkg::*;

	localparam int ITEM_GOAL    = 2000;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_LIMIT  = 4000;
	localparam int RUN_LIMIT_NS = 20_000_000;

	logic clk;
	logic arst_n;
	int   mismatches, outstanding, compared;
	int   n_items, n_ticks, n_writes, n_rx_reads;
	int   hold_reqs, holds_done;
	bit   calm, gaps_on, stalls_on;

	akl_in_if  cmd_ch ();
	akl_out_if res_ch ();

	acia_keyboard_link_model dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	akl_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_ch),
		.res         (res_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.compared    (compared)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("Timeout: run did not finish, %0d responses outstanding", outstanding);
		$display("Simulation FAILED");
		$finish;
	end

	// Offer one request and hold it until the transfer.
	task automatic issue(op_t o, reg_t a, logic [7:0] d);
		int gap;
		gap = (!calm && gaps_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 9) : 0;
		if (gap != 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.op    <= o;
		cmd_ch.addr  <= a;
		cmd_ch.wdata <= d;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		n_items++;
		if (o == OP_TICK)
			n_ticks++;
		if (o == OP_WRITE)
			n_writes++;
		if (o == OP_READ && a == REG_RXDATA)
			n_rx_reads++;
		if ($urandom_range(0, 149) == 0)
			gaps_on = !gaps_on;
	endtask

	task automatic run_ticks(int n);
		repeat (n) begin
			if ($urandom_range(0, 19) == 0)
				issue(OP_READ, REG_STATUS, 8'($urandom_range(0, 255)));
			issue(OP_TICK, reg_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
		end
	endtask

	// Response side: random stall bursts, plus one long hold-off on request.
	initial begin
		int gap;
		res_ch.ready <= 1'b0;
		stalls_on = 1'b1;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (holds_done != hold_reqs) begin
				holds_done++;
				gap = LONG_HOLD;
			end else if (!calm && stalls_on && $urandom_range(0, 6) == 0) begin
				gap = $urandom_range(1, 9);
			end else begin
				gap = 0;
			end
			if (gap != 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			if ($urandom_range(0, 199) == 0)
				stalls_on = !stalls_on;
		end
	end

	initial begin : stimulus
		int         kind, nb, c, nseq, w;
		logic [7:0] d;
		arst_n = 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.op    <= OP_READ;
		cmd_ch.addr  <= REG_STATUS;
		cmd_ch.wdata <= 8'h00;
		gaps_on = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values, status write masking, bit-7 interrupt, all baud rates
		issue(OP_READ, REG_STATUS, 8'h00);
		issue(OP_READ, REG_CONTROL, 8'hFF);
		issue(OP_READ, REG_TXDATA, 8'h00);
		issue(OP_READ, REG_RXDATA, 8'hFF);
		issue(OP_WRITE, REG_STATUS, 8'hFF);
		issue(OP_READ, REG_STATUS, 8'h00);
		issue(OP_ACK, REG_STATUS, 8'hFF);
		issue(OP_WRITE, REG_STATUS, 8'h00);
		issue(OP_WRITE, REG_CONTROL, 8'h03);
		issue(OP_WRITE, REG_CONTROL, 8'h82);
		issue(OP_ACK, REG_RXDATA, 8'h00);
		issue(OP_WRITE, REG_CONTROL, 8'h01);
		issue(OP_WRITE, REG_RXDATA, 8'hFF);
		issue(OP_READ, REG_RXDATA, 8'h00);
		issue(OP_WRITE, REG_TXDATA, 8'h00);
		issue(OP_WRITE, REG_TXDATA, 8'hFF);
		issue(OP_READ, REG_TXDATA, 8'h00);
		issue(OP_READ, REG_STATUS, 8'h00);
		issue(OP_WRITE, REG_CONTROL, 8'h00);
		issue(OP_TICK, REG_TXDATA, 8'hA5);
		issue(OP_READ, REG_CONTROL, 8'h00);
		issue(OP_ACK, REG_CONTROL, 8'h5A);
		issue(OP_READ, REG_RXDATA, 8'h00);

		// pause until every response is back
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);

		// first sequence fills both rings while the response side holds off
		hold_reqs++;
		nseq = 0;
		while (n_items < ITEM_GOAL) begin
			kind = (nseq == 0) ? 86 : $urandom_range(0, 99);
			nseq++;
			if (kind < 18) begin
				repeat ($urandom_range(1, 12))
					issue(op_t'($urandom_range(0, 3)), reg_t'($urandom_range(0, 3)),
						8'($urandom_range(0, 255)));
			end else if (kind < 46) begin
				// queue bytes at one baud rate, then tick long enough to loop them back
				c = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(0, 3);
				if ($urandom_range(0, 1))
					issue(OP_ACK, reg_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
				d = 8'($urandom_range(0, 255));
				d[1:0] = 2'(c);
				if ($urandom_range(0, 3) != 0)
					d[7] = 1'b0;
				issue(OP_WRITE, REG_CONTROL, d);
				nb = $urandom_range(1, (c == 0) ? 36 : 4);
				repeat (nb) issue(OP_WRITE, REG_TXDATA, 8'($urandom_range(0, 255)));
				run_ticks(nb * (32 << c) + $urandom_range(0, 40));
			end else if (kind < 66) begin
				repeat ($urandom_range(1, 70))
					issue(OP_READ, ($urandom_range(0, 3) == 0) ? REG_STATUS : REG_RXDATA,
						8'($urandom_range(0, 255)));
			end else if (kind < 84) begin
				repeat ($urandom_range(1, 6)) begin
					case ($urandom_range(0, 5))
					0: issue(OP_WRITE, REG_STATUS, 8'($urandom_range(0, 255)));
					1: issue(OP_WRITE, REG_CONTROL, 8'($urandom_range(0, 255)));
					2: issue(OP_WRITE, REG_RXDATA, 8'($urandom_range(0, 255)));
					3: issue(OP_ACK, reg_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
					default: issue(OP_READ, reg_t'($urandom_range(0, 3)),
						8'($urandom_range(0, 255)));
					endcase
				end
			end else if (kind < 90) begin
				// overflow the transmit ring, then loop back enough to overflow receive
				d = 8'($urandom_range(0, 255));
				d[1:0] = 2'b00;
				issue(OP_WRITE, REG_CONTROL, d);
				repeat (2) begin
					repeat (TX_DEPTH - 1 + $urandom_range(0, 3))
						issue(OP_WRITE, REG_TXDATA, 8'($urandom_range(0, 255)));
					run_ticks((TX_DEPTH - 1) * BAUD_BASE + $urandom_range(0, 64));
				end
			end else begin
				run_ticks($urandom_range(50, 600));
			end
		end

		// last stretch runs without idling on either side
		calm = 1'b1;
		repeat (150)
			issue(op_t'($urandom_range(0, 3)), reg_t'($urandom_range(0, 3)),
				8'($urandom_range(0, 255)));
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		for (w = 0; w < DRAIN_LIMIT && outstanding != 0; w++)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d requests: %0d timer ticks, %0d register writes, %0d receive reads",
			n_items, n_ticks, n_writes, n_rx_reads);
		$display("Compared %0d responses, %0d mismatches, %0d never returned",
			compared, mismatches, outstanding);
		if (mismatches == 0 && outstanding == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

/* acia_keyboard_link_model.f */
+incdir+rtl
rtl/akl_pkg.sv
rtl/akl_in_if.sv
rtl/akl_out_if.sv
rtl/akl_rx_ring.sv
rtl/akl_outbuf.sv
rtl/akl_core.sv
rtl/acia_keyboard_link_model.sv
bench/akl_checker.sv
bench/testbench.sv
